@@ sv/xsr_pkg.sv @@
// ----------------------------------------------------------------------------
// xsr_pkg
// shared types, codes and constants of the xoshiro256** generator
// ----------------------------------------------------------------------------
package xsr_pkg;

  localparam int unsigned WordWidth = 64;
  localparam int unsigned HalfWidth = WordWidth / 2;
  localparam int unsigned NumWords  = 4;
  localparam int unsigned WordIdxW  = $clog2(NumWords);

  // splitmix64 constants
  localparam logic [WordWidth-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordWidth-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordWidth-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;

  // xoshiro256** constants
  localparam int unsigned UPD_SHIFT  = 17;
  localparam int unsigned UPD_ROT    = 45;
  localparam int unsigned SCR_ROT    = 7;
  localparam int unsigned SCR_SHL_5  = 2;   // x * 5 = x + (x << 2)
  localparam int unsigned SCR_SHL_9  = 3;   // x * 9 = x + (x << 3)

  // three partial products of a 64 x 64 multiply kept modulo 2^64
  localparam int unsigned MulSteps = 3;
  localparam int unsigned MulStepW = $clog2(MulSteps);
  localparam logic [MulStepW-1:0] MUL_LO_LO = 2'd0;
  localparam logic [MulStepW-1:0] MUL_HI_LO = 2'd1;
  localparam logic [MulStepW-1:0] MUL_LO_HI = 2'd2;

  typedef enum logic {
    OP_NEXT = 1'b0,
    OP_SEED = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_BEGIN,
    S_MUL_A,
    S_MID,
    S_MUL_B,
    S_STORE
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic                seed_load;
    logic                seed_zero;
    logic                mix_begin;
    logic                mul_en;
    logic [MulStepW-1:0] mul_step;
    logic                mul_sel_b;
    logic                mix_mid;
    logic                mix_store;
    logic [WordIdxW-1:0] word_idx;
    logic                advance;
  } xsr_cmd_t;

endpackage

@@ sv/xoshiro256starstar_generator_unit.sv @@
// ----------------------------------------------------------------------------
// xoshiro256starstar_generator_unit
// xoshiro256** random word generator with splitmix64 seeding
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_ready_o) carries one request per
//   transaction: opcode_i = next gives one random_word_o, opcode_i = seed
//   reloads the four state words from seed_value_i and gives nothing
//   output channel (out_valid_o / out_ready_i) carries one random word per
//   next transaction, from a registered output slot
// latency and throughput:
//   the word of a next request is valid the cycle after acceptance, and
//   a new request is taken every cycle while the receiver keeps up and
//   no seeding pass runs; a seed request ends before the next is taken:
//   four splitmix64 words, each a begin, three multiply, a mid, three
//   multiply and a store step, set by the shared 32 x 32 multiplier
//   that builds each 64-bit product over three partial products
// reset:
//   the block runs a seeding pass with seed zero, with in_ready_o low
//   until it ends
// stall:
//   while an unread word waits, a new request is taken only in the cycle
//   the receiver takes that word
// ----------------------------------------------------------------------------
module xoshiro256starstar_generator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [0:0]                     opcode_i,
  input  logic [xsr_pkg::WordWidth-1:0]  seed_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [xsr_pkg::WordWidth-1:0]  random_word_o
);
  import xsr_pkg::*;

  // command bundle from sequencer to datapath
  xsr_cmd_t cmd;

  // sequencer: seeding steps, request acceptance, output valid flag
  xsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath: state words, mixing, multiply steps, advance and output slot
  xsr_datapath u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .seed_value_i  (seed_value_i),
    .random_word_o (random_word_o)
  );

endmodule

@@ sv/xsr_datapath.sv @@
// ----------------------------------------------------------------------------
// xsr_datapath
// state words, splitmix64 seeding datapath with a shared 32 x 32 multiplier,
// and the xoshiro256** advance with its output register
// ----------------------------------------------------------------------------
module xsr_datapath (
  input  logic                            clk_i,
  input  xsr_pkg::xsr_cmd_t               cmd_i,
  input  logic [xsr_pkg::WordWidth-1:0]   seed_value_i,
  output logic [xsr_pkg::WordWidth-1:0]   random_word_o
);
  import xsr_pkg::*;

  logic [WordWidth-1:0] gen_q [NumWords];
  logic [WordWidth-1:0] gen_d [NumWords];
  logic [WordWidth-1:0] counter_q, counter_d;
  logic [WordWidth-1:0] mop_q, mop_d;
  logic [WordWidth-1:0] acc_q, acc_d;
  logic [WordWidth-1:0] word_q, word_d;

  logic [WordWidth-1:0] count_inc;
  logic [WordWidth-1:0] mul_const;
  logic [HalfWidth-1:0] mul_x, mul_y;
  logic [WordWidth-1:0] mul_prod;
  logic [WordWidth-1:0] times5, rot7, times9;

  assign count_inc = counter_q + GOLDEN_GAMMA;

  // shared multiplier, one partial product per cycle
  assign mul_const = cmd_i.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;
  assign mul_x     = (cmd_i.mul_step == MUL_HI_LO) ? mop_q[WordWidth-1:HalfWidth]
                                                   : mop_q[HalfWidth-1:0];
  assign mul_y     = (cmd_i.mul_step == MUL_LO_HI) ? mul_const[WordWidth-1:HalfWidth]
                                                   : mul_const[HalfWidth-1:0];
  assign mul_prod  = WordWidth'(mul_x) * WordWidth'(mul_y);

  // scrambler: rotl(s1 * 5, 7) * 9
  assign times5 = gen_q[1] + (gen_q[1] << SCR_SHL_5);
  assign rot7   = (times5 << SCR_ROT) | (times5 >> (WordWidth - SCR_ROT));
  assign times9 = rot7 + (rot7 << SCR_SHL_9);

  always_comb begin
    counter_d = counter_q;
    mop_d     = mop_q;
    acc_d     = acc_q;
    word_d    = word_q;
    for (int i = 0; i < NumWords; i++) begin
      gen_d[i] = gen_q[i];
    end

    if (cmd_i.seed_load) begin
      counter_d = cmd_i.seed_zero ? '0 : seed_value_i;
    end

    if (cmd_i.mix_begin) begin
      counter_d = count_inc;
      mop_d     = count_inc ^ (count_inc >> MIX_SHIFT_A);
    end

    if (cmd_i.mix_mid) begin
      mop_d = acc_q ^ (acc_q >> MIX_SHIFT_B);
    end

    if (cmd_i.mul_en) begin
      if (cmd_i.mul_step == MUL_LO_LO) begin
        acc_d = mul_prod;
      end else begin
        acc_d = acc_q + {mul_prod[HalfWidth-1:0], {HalfWidth{1'b0}}};
      end
    end

    if (cmd_i.mix_store) begin
      gen_d[cmd_i.word_idx] = acc_q ^ (acc_q >> MIX_SHIFT_C);
    end

    if (cmd_i.advance) begin
      word_d   = times9;
      gen_d[0] = gen_q[0] ^ gen_q[3] ^ gen_q[1];
      gen_d[1] = gen_q[1] ^ gen_q[2] ^ gen_q[0];
      gen_d[2] = gen_q[2] ^ gen_q[0] ^ (gen_q[1] << UPD_SHIFT);
      gen_d[3] = ((gen_q[3] ^ gen_q[1]) << UPD_ROT)
               | ((gen_q[3] ^ gen_q[1]) >> (WordWidth - UPD_ROT));
    end
  end

  // payload registers with no reset; the seeding pass that follows reset fills the counter and state words
  always_ff @(posedge clk_i) begin
    counter_q <= counter_d;
    mop_q     <= mop_d;
    acc_q     <= acc_d;
    word_q    <= word_d;
    for (int i = 0; i < NumWords; i++) begin
      gen_q[i] <= gen_d[i];
    end
  end

  assign random_word_o = word_q;

endmodule

@@ sv/xsr_ctrl.sv @@
// ----------------------------------------------------------------------------
// xsr_ctrl
// sequencer for seeding and next requests, plus the output valid flag
// ----------------------------------------------------------------------------
module xsr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [0:0]         opcode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output xsr_pkg::xsr_cmd_t  cmd_o
);
  import xsr_pkg::*;

  state_e               state_q, state_d;
  logic [MulStepW-1:0]  step_q, step_d;
  logic [WordIdxW-1:0]  word_q, word_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;
  logic                 is_seed;
  logic                 last_step;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_seed    = (opcode_i == OP_SEED);
  assign last_step  = (step_q == MUL_LO_HI);

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    word_d  = word_q;
    unique case (state_q)
      S_INIT: begin
        state_d = S_BEGIN;
        word_d  = '0;
      end
      S_IDLE: begin
        if (accept && is_seed) begin
          state_d = S_BEGIN;
          word_d  = '0;
        end
      end
      S_BEGIN: begin
        state_d = S_MUL_A;
        step_d  = MUL_LO_LO;
      end
      S_MUL_A: begin
        step_d = step_q + 1'b1;
        if (last_step) begin
          state_d = S_MID;
        end
      end
      S_MID: begin
        state_d = S_MUL_B;
        step_d  = MUL_LO_LO;
      end
      S_MUL_B: begin
        step_d = step_q + 1'b1;
        if (last_step) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        word_d = word_q + 1'b1;
        if (word_q == WordIdxW'(NumWords - 1)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_BEGIN;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_step = step_q;
    cmd_o.word_idx = word_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.seed_load = 1'b1;
        cmd_o.seed_zero = 1'b1;
      end
      S_IDLE: begin
        cmd_o.seed_load = accept && is_seed;
        cmd_o.advance   = accept && !is_seed;
      end
      S_BEGIN: cmd_o.mix_begin = 1'b1;
      S_MUL_A: cmd_o.mul_en    = 1'b1;
      S_MID:   cmd_o.mix_mid   = 1'b1;
      S_MUL_B: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel_b = 1'b1;
      end
      S_STORE: cmd_o.mix_store = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      step_q      <= '0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ tb/tb_xoshiro256starstar_generator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_xoshiro256starstar_generator_unit
// self-checking bench for the xoshiro256** generator with splitmix64 seeding
// ----------------------------------------------------------------------------
// a table of directed requests runs first, then about 1430 random requests
// with bursty input traffic and a patterned output stall; every accepted
// request updates a local copy of the four state words, and each next
// request queues the word it must give, which the output monitor checks
// in order
// ----------------------------------------------------------------------------
module tb_xoshiro256starstar_generator_unit;
  import xsr_pkg::*;

  localparam int unsigned RandomItems = 1430;
  localparam int unsigned DirectedItems = 20;
  localparam int unsigned LongHoldCycles = 200;
  localparam int unsigned DrainLimit = 20000;

  typedef logic [WordWidth-1:0] word_t;

  typedef struct {
    opcode_e op;
    word_t   seed;
  } request_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [0:0]  opcode_i;
  word_t       seed_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  word_t       random_word_o;

  // local copy of the generator state words
  word_t       gen_words [NumWords];
  // words still owed by the block, oldest first
  word_t       pending_words [$];
  word_t       owed_word;
  int unsigned fail_count;
  // asks the receiver for its one long hold-off
  logic        long_hold_req;

  xoshiro256starstar_generator_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .seed_value_i (seed_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .random_word_o(random_word_o)
  );

  // --------------------------------------------------------------------------
  // state predictor
  // --------------------------------------------------------------------------

  function automatic word_t rotl64(word_t v, int unsigned amount);
    return (v << amount) | (v >> (WordWidth - amount));
  endfunction

  // splitmix64 finalizer applied to one counter value
  function automatic word_t splitmix_out(word_t counter);
    word_t z;
    z = counter;
    z = (z ^ (z >> MIX_SHIFT_A)) * MIX_MUL_A;
    z = (z ^ (z >> MIX_SHIFT_B)) * MIX_MUL_B;
    return z ^ (z >> MIX_SHIFT_C);
  endfunction

  // fill the four words from successive splitmix64 outputs
  function automatic void load_gen_seed(word_t seed);
    word_t counter;
    counter = seed;
    for (int i = 0; i < NumWords; i++) begin
      counter = counter + GOLDEN_GAMMA;
      gen_words[i] = splitmix_out(counter);
    end
  endfunction

  // scrambled word of the current state, then the xor/shift/rotate update
  function automatic word_t advance_gen_words();
    word_t scrambled;
    word_t shifted;
    scrambled = rotl64(gen_words[1] * 5, SCR_ROT) * 9;
    shifted   = gen_words[1] << UPD_SHIFT;
    gen_words[2] ^= gen_words[0];
    gen_words[3] ^= gen_words[1];
    gen_words[1] ^= gen_words[2];
    gen_words[0] ^= gen_words[3];
    gen_words[2] ^= shifted;
    gen_words[3] = rotl64(gen_words[3], UPD_ROT);
    return scrambled;
  endfunction

  function automatic void predict_request(opcode_e op, word_t seed);
    if (op == OP_SEED) begin
      load_gen_seed(seed);
    end else begin
      pending_words.push_back(advance_gen_words());
    end
  endfunction

  // --------------------------------------------------------------------------
  // clock and time limit
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // time limit, well beyond the slowest legal run
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern that rotates through four modes, plus one long hold
  // --------------------------------------------------------------------------

  initial begin : receiver
    int unsigned rx_cycle;
    int unsigned hold_left;
    bit          hold_served;
    rx_cycle    = 0;
    hold_left   = 0;
    hold_served = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (long_hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = LongHoldCycles;
      end
      if (hold_left != 0) begin
        // output slot fills and the block must stall its input
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0: out_ready_i <= 1'b1;                         // no stalls at all
          1: out_ready_i <= 1'($urandom);                 // coin flip
          2: out_ready_i <= ((rx_cycle % 4) != 3);        // one stall in four
          default: out_ready_i <= ((rx_cycle % 5) == 0);  // mostly stalled
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // output monitor: every word taken must match the oldest owed word
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: random word with none owed: expected none, actual %h",
                 $time, random_word_o);
        fail_count++;
      end else begin
        owed_word = pending_words.pop_front();
        if (random_word_o !== owed_word) begin
          $display("%0t: random_word mismatch: expected %h, actual %h",
                   $time, owed_word, random_word_o);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender helpers, all entered and left at a falling edge
  // --------------------------------------------------------------------------

  // hold one request until the block takes it, then predict its effect
  task automatic send_request(opcode_e op, word_t seed);
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    seed_value_i <= seed;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(op, seed);
    @(negedge clk_i);
  endtask

  // idle gap with junk on the payload lines
  task automatic idle_input(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) begin
      opcode_i     <= 1'($urandom);
      seed_value_i <= {$urandom, $urandom};
      @(negedge clk_i);
    end
  endtask

  // sender pause until every owed word has been taken
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_words.size() != 0);
  endtask

  function automatic word_t random_seed();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WordWidth - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  initial begin : stimulus
    request_t    directed_reqs [DirectedItems];
    int unsigned burst_left;
    int unsigned steady_left;
    int unsigned settle_cycles;
    opcode_e     op;

    fail_count    = 0;
    long_hold_req = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = OP_NEXT;
    seed_value_i  = '0;
    rst_ni        = 1'b0;

    // reset state equals a reseed with zero; seed lines are ignored on next
    directed_reqs = '{
      '{OP_NEXT, 64'h0000_0000_0000_0000},  // first word of the reset state
      '{OP_NEXT, 64'hFFFF_FFFF_FFFF_FFFF},  // seed field set but ignored
      '{OP_NEXT, 64'h0000_0000_0000_0000},
      '{OP_SEED, 64'h0000_0000_0000_0000},  // back to the reset state
      '{OP_NEXT, 64'hFFFF_FFFF_FFFF_FFFF},
      '{OP_NEXT, 64'h0000_0000_0000_0000},
      '{OP_SEED, 64'hFFFF_FFFF_FFFF_FFFF},  // largest seed
      '{OP_NEXT, 64'h0000_0000_0000_0000},
      '{OP_NEXT, 64'h0000_0000_0000_0000},
      '{OP_SEED, 64'h0000_0000_0000_0001},
      '{OP_SEED, 64'h8000_0000_0000_0000},  // reseed right after a reseed
      '{OP_NEXT, 64'hAAAA_AAAA_AAAA_AAAA},
      '{OP_NEXT, 64'h5555_5555_5555_5555},
      '{OP_SEED, 64'h5555_5555_5555_5555},
      '{OP_NEXT, 64'h0000_0000_0000_0000},
      '{OP_SEED, 64'hAAAA_AAAA_AAAA_AAAA},
      '{OP_NEXT, 64'h0000_0000_0000_0000},
      '{OP_NEXT, 64'h0000_0000_0000_0000},
      '{OP_SEED, 64'h0123_4567_89AB_CDEF},
      '{OP_NEXT, 64'h0000_0000_0000_0000}
    };

    load_gen_seed('0);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, back to back
    for (int i = 0; i < DirectedItems; i++) begin
      send_request(directed_reqs[i].op, directed_reqs[i].seed);
    end

    // random part: bursts of requests with idle gaps, few reseeds
    burst_left  = 0;
    steady_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n == 400) begin
        // receiver goes quiet while requests keep coming back to back
        long_hold_req <= 1'b1;
        steady_left = 40;
      end
      if (n == 900) begin
        wait_for_drain();
      end
      if (steady_left != 0) begin
        steady_left--;
      end else if (burst_left == 0) begin
        idle_input($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
      op = ($urandom_range(0, 99) < 6) ? OP_SEED : OP_NEXT;
      send_request(op, random_seed());
    end
    in_valid_i <= 1'b0;

    // let every owed word come out, then allow for a trailing reseed pass
    settle_cycles = 0;
    while (pending_words.size() != 0 && settle_cycles < DrainLimit) begin
      @(negedge clk_i);
      settle_cycles++;
    end
    if (pending_words.size() != 0) begin
      $display("%0t: %0d random words never came out: expected %h, actual none",
               $time, pending_words.size(), pending_words[0]);
      fail_count++;
    end
    repeat (40) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ xoshiro256starstar_generator_unit.f @@
sv/xsr_pkg.sv
sv/xsr_datapath.sv
sv/xsr_ctrl.sv
sv/xoshiro256starstar_generator_unit.sv
tb/tb_xoshiro256starstar_generator_unit.sv
